@@ rtl/core/yc2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// yc2rgb_pkg: shared types and constants for the YCbCr 4:2:0 to RGB332 path
// Item and stage payload structs, BT.601 gains, Bayer thresholds, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package yc2rgb_pkg;

  localparam int PROD_W = 26;
  localparam int SUM_W  = 12;

  localparam logic signed [PROD_W-1:0] LUMA_GAIN = 26'sd76309;
  localparam logic signed [PROD_W-1:0] CR_TO_R   = 26'sd104597;
  localparam logic signed [PROD_W-1:0] CB_TO_G   = 26'sd25674;
  localparam logic signed [PROD_W-1:0] CR_TO_G   = 26'sd53278;
  localparam logic signed [PROD_W-1:0] CB_TO_B   = 26'sd132201;

  localparam logic [8:0] LUMA_OFFSET   = 9'd16;
  localparam logic [8:0] CHROMA_OFFSET = 9'd128;

  localparam logic [3:0][6:0] RG_THRESH = {7'd9, 7'd27, 7'd18, 7'd0};
  localparam logic [3:0][6:0] B_THRESH  = {7'd21, 7'd64, 7'd42, 7'd0};

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_top_left;
    logic [7:0] pixel_top_right;
    logic [7:0] pixel_bottom_left;
    logic [7:0] pixel_bottom_right;
  } out_t;

  typedef struct packed {
    logic [3:0][PROD_W-1:0] luma;
    logic [PROD_W-1:0]      red;
    logic [PROD_W-1:0]      green_cb;
    logic [PROD_W-1:0]      green_cr;
    logic [PROD_W-1:0]      blue;
  } prod_t;

  typedef struct packed {
    logic [3:0][7:0]   luma;
    logic signed [8:0] red;
    logic signed [8:0] green;
    logic signed [9:0] blue;
  } delta_t;

  function automatic logic [7:0] clamp255(input logic signed [SUM_W-1:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 12'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/yc2rgb_mult.sv @@
// ----------------------------------------------------------------------------
// yc2rgb_mult: first stage, offset removal and gain multiplies
// Registers the luma and chroma products of one 2x2 block.
// ----------------------------------------------------------------------------
`default_nettype none

module yc2rgb_mult
  import yc2rgb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  valid_in,
  input  wire in_t   data_in,
  output logic       valid_out,
  output prod_t      data_out
);

  logic [3:0][7:0]          luma_raw;
  logic [3:0][PROD_W-1:0]   luma_ext;
  logic signed [8:0]        cb9;
  logic signed [8:0]        cr9;
  logic signed [PROD_W-1:0] cb_ext;
  logic signed [PROD_W-1:0] cr_ext;
  prod_t                    prod_next;

  assign luma_raw = {data_in.luma_bottom_right, data_in.luma_bottom_left,
                     data_in.luma_top_right, data_in.luma_top_left};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      luma_ext[i] = PROD_W'($signed({1'b0, luma_raw[i]} - LUMA_OFFSET));
      prod_next.luma[i] = $signed(luma_ext[i]) * LUMA_GAIN;
    end
    cb9    = $signed({1'b0, data_in.chroma_blue} - CHROMA_OFFSET);
    cr9    = $signed({1'b0, data_in.chroma_red} - CHROMA_OFFSET);
    cb_ext = PROD_W'(cb9);
    cr_ext = PROD_W'(cr9);
    prod_next.red      = cr_ext * CR_TO_R;
    prod_next.green_cb = cb_ext * CB_TO_G;
    prod_next.green_cr = cr_ext * CR_TO_G;
    prod_next.blue     = cb_ext * CB_TO_B;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= prod_next;
  end

endmodule

`default_nettype wire

@@ rtl/core/yc2rgb_scale.sv @@
// ----------------------------------------------------------------------------
// yc2rgb_scale: second stage, fixed-point scaling
// Floors the products by 2^16, sums the green terms and clamps luma.
// ----------------------------------------------------------------------------
`default_nettype none

module yc2rgb_scale
  import yc2rgb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  valid_in,
  input  wire prod_t data_in,
  output logic       valid_out,
  output delta_t     data_out
);

  logic [PROD_W-1:0] green_sum;
  delta_t            delta_next;

  always_comb begin
    green_sum = data_in.green_cb + data_in.green_cr;
    for (int i = 0; i < 4; i++) begin
      delta_next.luma[i] = clamp255(SUM_W'($signed(data_in.luma[i][25:16])));
    end
    delta_next.red   = $signed(data_in.red[24:16]);
    delta_next.green = $signed(green_sum[24:16]);
    delta_next.blue  = $signed(data_in.blue[25:16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= delta_next;
  end

endmodule

`default_nettype wire

@@ rtl/core/yc2rgb_dither.sv @@
// ----------------------------------------------------------------------------
// yc2rgb_dither: third stage, ordered dither and RGB332 packing
// Adds luma, chroma deltas (green subtracted) and Bayer thresholds per pixel, clamps and packs.
// ----------------------------------------------------------------------------
`default_nettype none

module yc2rgb_dither
  import yc2rgb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   valid_in,
  input  wire delta_t data_in,
  output logic        valid_out,
  output out_t        data_out
);

  logic signed [SUM_W-1:0] y_ext;
  logic signed [SUM_W-1:0] r_sum;
  logic signed [SUM_W-1:0] g_sum;
  logic signed [SUM_W-1:0] b_sum;
  logic [7:0]              r_val;
  logic [7:0]              g_val;
  logic [7:0]              b_val;
  logic [3:0][7:0]         pix;

  always_comb begin
    y_ext = '0;
    r_sum = '0;
    g_sum = '0;
    b_sum = '0;
    r_val = '0;
    g_val = '0;
    b_val = '0;
    for (int p = 0; p < 4; p++) begin
      y_ext = $signed({4'b0, data_in.luma[p]});
      r_sum = y_ext + SUM_W'(data_in.red) + $signed({5'b0, RG_THRESH[p]});
      g_sum = y_ext - SUM_W'(data_in.green) + $signed({5'b0, RG_THRESH[p]});
      b_sum = y_ext + SUM_W'(data_in.blue) + $signed({5'b0, B_THRESH[p]});
      r_val = clamp255(r_sum);
      g_val = clamp255(g_sum);
      b_val = clamp255(b_sum);
      pix[p] = {r_val[7:5], g_val[7:5], b_val[7:6]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_out.pixel_top_left     <= pix[0];
    data_out.pixel_top_right    <= pix[1];
    data_out.pixel_bottom_left  <= pix[2];
    data_out.pixel_bottom_right <= pix[3];
  end

endmodule

`default_nettype wire

@@ rtl/core/ycbcr420_to_rgb332_bayer_dither.sv @@
// ----------------------------------------------------------------------------
// ycbcr420_to_rgb332_bayer_dither: 2x2 YCbCr 4:2:0 block to four RGB332 pixels
// Pipeline: start and samples pass through three register stages (multiply,
// scale, dither); done is the valid bit of the dither stage.
// Throughput: one block per cycle, set by the three-stage multiply/scale/dither
// pipeline; busy stays low since the receiver cannot stall.
// Reset: synchronous rst clears the stage valid bits; items in flight drop.
// ----------------------------------------------------------------------------
`default_nettype none

module ycbcr420_to_rgb332_bayer_dither
  import yc2rgb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  samples,
  output logic      done,
  output out_t      pixels
);

  logic   mult_valid;
  prod_t  mult_data;
  logic   scale_valid;
  delta_t scale_data;

  assign busy = 1'b0;

  yc2rgb_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start),
    .data_in   (samples),
    .valid_out (mult_valid),
    .data_out  (mult_data)
  );

  yc2rgb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (mult_valid),
    .data_in   (mult_data),
    .valid_out (scale_valid),
    .data_out  (scale_data)
  );

  yc2rgb_dither u_dither (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (scale_valid),
    .data_in   (scale_data),
    .valid_out (done),
    .data_out  (pixels)
  );

endmodule

`default_nettype wire
